// File: rtl/esc_pkg.sv
// Shared types, constants and helpers for the escalator speed controller.
// No dependencies; esc_cfg, esc_step and the top level import this package.
package esc_pkg;

  localparam int COUNT_W  = 16;
  localparam int TIMER_W  = 22;
  localparam int WAIT_W   = 12;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [TIMER_W-1:0] TIMER_MAX    = {TIMER_W{1'b1}};
  localparam logic [TIMER_W-1:0] REARM_TICKS  = TIMER_W'(1000);
  localparam logic [COUNT_W-1:0] THRESH_RESET = COUNT_W'(5);
  localparam int                 WAIT_RESET   = 5;

  typedef enum logic [2:0] {
    MODE_DISABLED = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_SLOW     = 3'd2,
    MODE_FAST     = 3'd3,
    MODE_WAITING  = 3'd4
  } esc_mode_t;

  typedef enum logic [1:0] {
    EV_NONE          = 2'd0,
    EV_DEACTIVATE    = 2'd1,
    EV_ACTIVATE_DOWN = 2'd2,
    EV_ENTRY         = 2'd3
  } esc_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_WAIT      = 1'b1
  } esc_cfg_idx_t;

  // Architectural state carried between the state register and the step logic
  typedef struct packed {
    esc_mode_t            mode;
    logic [COUNT_W-1:0]   count;
    logic [TIMER_W-1:0]   timer;
    esc_event_t           latched;
  } esc_state_t;

  // Saturating occupancy increment
  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
    count_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

  // Occupancy decrement that stops at zero
  function automatic logic [COUNT_W-1:0] count_dec(input logic [COUNT_W-1:0] c);
    count_dec = (c == '0) ? c : c - COUNT_W'(1);
  endfunction

endpackage

// File: rtl/esc_sensor_if.sv
// Input channel: one sensor transaction per handshake.
// Depends on nothing; widths follow the sensor item fields.
interface esc_sensor_if;
  logic       valid;
  logic       ready;
  logic       tick;
  logic [1:0] event_req;
  logic       no_deactivate_request;
  logic       entry_seen;
  logic       exit_seen;
  logic       barrier_clear;

  modport source (output valid, tick, event_req, no_deactivate_request, entry_seen,
                  exit_seen, barrier_clear, input ready);
  modport sink   (input valid, tick, event_req, no_deactivate_request, entry_seen,
                  exit_seen, barrier_clear, output ready);
endinterface

// File: rtl/esc_status_if.sv
// Output channel: mode and occupancy after each sensor transaction.
// Depends on nothing; widths follow the status item fields.
interface esc_status_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] occupancy;

  modport source (output valid, mode, occupancy, input ready);
  modport sink   (input valid, mode, occupancy, output ready);
endinterface

// File: rtl/esc_cfg.sv
// Configuration registers: fast-mode threshold and precomputed wait load.
// Depends on esc_pkg.
module esc_cfg #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esc_pkg::CFG_W-1:0]     cfg_data,
  output logic [esc_pkg::COUNT_W-1:0]   threshold,
  output logic [esc_pkg::TIMER_W-1:0]   wait_load
);
  import esc_pkg::*;

  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int PROD_W = (WAIT_W + TPS_W > TIMER_W) ? WAIT_W + TPS_W : TIMER_W;
  localparam logic [PROD_W-1:0] TPS_K     = PROD_W'(TICKS_PER_SECOND);
  localparam logic [PROD_W-1:0] RST_PROD  = PROD_W'(WAIT_RESET * TICKS_PER_SECOND);

  function automatic logic [TIMER_W-1:0] sat_timer(input logic [PROD_W-1:0] p);
    sat_timer = (p > PROD_W'(TIMER_MAX)) ? TIMER_MAX : p[TIMER_W-1:0];
  endfunction

  logic [PROD_W-1:0] prod;

  // Seconds to ticks, done once at write time
  assign prod = PROD_W'(cfg_data[WAIT_W-1:0]) * TPS_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      wait_load <= sat_timer(RST_PROD);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data[COUNT_W-1:0];
        CFG_WAIT:      wait_load <= sat_timer(prod);
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/esc_step.sv
// Next-state logic for one sensor transaction: event latch and mode machine.
// Depends on esc_pkg.
module esc_step (
  input  esc_pkg::esc_state_t           st,
  input  logic                          tick,
  input  logic [1:0]                    event_req,
  input  logic                          no_deactivate_request,
  input  logic                          entry_seen,
  input  logic                          exit_seen,
  input  logic                          barrier_clear,
  input  logic [esc_pkg::COUNT_W-1:0]   threshold,
  input  logic [esc_pkg::TIMER_W-1:0]   wait_load,
  output esc_pkg::esc_state_t           st_next
);
  import esc_pkg::*;

  esc_event_t         ev;
  esc_mode_t          m;
  logic [COUNT_W-1:0] c;
  logic [TIMER_W-1:0] t;

  always_comb begin
    // A new event overwrites the latch before the step
    ev = (esc_event_t'(event_req) != EV_NONE) ? esc_event_t'(event_req) : st.latched;
    m  = st.mode;
    c  = st.count;
    t  = st.timer;

    if (tick) begin
      if (ev == EV_DEACTIVATE) begin
        m = MODE_DISABLED;
        c = '0;
      end
      case (m)
        MODE_IDLE: begin
          if (entry_seen) begin
            c = count_inc(c);
            m = MODE_SLOW;
          end
          if (!barrier_clear) m = MODE_SLOW;
        end
        MODE_SLOW: begin
          // entry comes from the latched event here, not the sensor
          if (ev == EV_ENTRY) c = count_inc(c);
          if (exit_seen) c = count_dec(c);
          if (c >= threshold) begin
            m = MODE_FAST;
          end else if (c == '0) begin
            t = wait_load;
            m = MODE_WAITING;
          end
        end
        MODE_FAST: begin
          if (entry_seen) c = count_inc(c);
          if (exit_seen) c = count_dec(c);
          if (c < threshold) m = MODE_SLOW;
        end
        MODE_WAITING: begin
          if (entry_seen) begin
            c = count_inc(c);
            m = MODE_SLOW;
          end else if (t != '0) begin
            t = t - TIMER_W'(1);
          end else if (barrier_clear) begin
            m = MODE_IDLE;
          end else begin
            t = REARM_TICKS;
          end
        end
        default: begin
          m = (ev == EV_ACTIVATE_DOWN && no_deactivate_request) ? MODE_IDLE : MODE_DISABLED;
        end
      endcase
      ev = EV_NONE;
    end

    st_next.mode    = m;
    st_next.count   = c;
    st_next.timer   = t;
    st_next.latched = ev;
  end

endmodule

// File: rtl/escalator_occupancy_speed_control.sv
// Escalator mode controller, top level: state register, result register.
// Depends on esc_pkg, esc_sensor_if, esc_status_if, esc_cfg, esc_step.
//
// Usage:
//   sensor  - one transaction per item: a millisecond tick flag, an optional
//             system event and the sensor flags. With tick low only the event
//             is latched; with tick high the mode machine takes one step.
//   status  - one transaction per sensor transaction: mode and occupancy
//             after that item, in order.
//   cfg_*   - write port for the fast threshold (index 0) and the wait time
//             in seconds (index 1); write only while no result is pending.
// Status valid rises in the cycle after sensor acceptance. Throughput is
// one item per cycle while status is not stalled: the step is a single pass
// of small logic from the state register back into itself, and the result
// register takes the new value in the same edge.
// When status is stalled the result register holds and sensor.ready drops
// until the result is taken; a result being taken frees room that same cycle.
// Reset: mode disabled, occupancy zero, timer zero, no latched event,
// threshold 5, wait 5 seconds, no result pending.
module escalator_occupancy_speed_control #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  esc_sensor_if.sink                    sensor,
  esc_status_if.source                  status,
  input  logic                          cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esc_pkg::CFG_W-1:0]     cfg_data
);
  import esc_pkg::*;

  logic [COUNT_W-1:0] threshold;
  logic [TIMER_W-1:0] wait_load;
  esc_state_t         st;
  esc_state_t         st_next;
  logic               accept;
  logic               out_valid;
  esc_mode_t          out_mode;
  logic [COUNT_W-1:0] out_count;

  esc_cfg #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .threshold (threshold),
    .wait_load (wait_load)
  );

  esc_step u_step (
    .st                    (st),
    .tick                  (sensor.tick),
    .event_req             (sensor.event_req),
    .no_deactivate_request (sensor.no_deactivate_request),
    .entry_seen            (sensor.entry_seen),
    .exit_seen             (sensor.exit_seen),
    .barrier_clear         (sensor.barrier_clear),
    .threshold             (threshold),
    .wait_load             (wait_load),
    .st_next               (st_next)
  );

  // Accept whenever the result register is empty or being drained
  assign sensor.ready = !out_valid || status.ready;
  assign accept       = sensor.valid && sensor.ready;

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode    <= MODE_DISABLED;
      st.count   <= '0;
      st.timer   <= '0;
      st.latched <= EV_NONE;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mode  <= st_next.mode;
      out_count <= st_next.count;
    end
  end

  assign status.valid     = out_valid;
  assign status.mode      = out_mode;
  assign status.occupancy = out_count;

  // A tick always leaves the event latch empty
  a_latch_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && sensor.tick |=> st.latched == EV_NONE)
    else $error("event latch not cleared after tick");

  // Disabled and waiting modes only exist with an empty escalator
  a_empty_modes: assert property (@(posedge clk) disable iff (rst)
    (st.mode == MODE_DISABLED || st.mode == MODE_WAITING) |-> st.count == '0)
    else $error("nonzero occupancy in disabled or waiting mode");

  // A pending result always mirrors the current state
  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count == st.count && out_mode == st.mode))
    else $error("result register out of step with state");

  // No new transaction while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status.ready |-> !accept)
    else $error("sensor accepted over a stalled result");

endmodule
